// ----- rtl/pwcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pwcc_pkg
// Shared types and constants for the pulse width classifying counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pwcc_pkg;

    localparam int unsigned CntW   = 32;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned WidthW = 16;
    localparam int unsigned CmdW   = 2;
    localparam int unsigned ApbDW  = 32;
    localparam int unsigned ApbAW  = 4;

    // Weight of a pulse above the long threshold
    localparam logic [1:0] LongWeight = 2'd2;

    // Reset values of the configuration registers
    localparam logic [WidthW-1:0] DeadTimeRst  = 16'd20;
    localparam logic [WidthW-1:0] MaxPulseRst  = 16'd500;
    localparam logic [WidthW-1:0] LongPulseRst = 16'd150;

    // Event commands
    typedef enum logic [CmdW-1:0] {
        CMD_FALL = 2'd0,
        CMD_RISE = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // Register word index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_DEAD_TIME  = 2'd0,
        REG_MAX_PULSE  = 2'd1,
        REG_LONG_PULSE = 2'd2
    } t_reg_idx;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        logic [WidthW-1:0] dead_time_us;
        logic [WidthW-1:0] max_pulse_us;
        logic [WidthW-1:0] long_pulse_us;
    } t_cfg;

endpackage : pwcc_pkg

`default_nettype wire

// ----- rtl/pulse_width_classifying_counter_unit.sv -----
// Path: an accepted word is held in the input register, passes the counter
// update and is written to the result register once that register is free.
// Throughput: one word per cycle unless the output stalls; the counter update
// sits in a single stage between the input register and the result register.
// Reset (synchronous, active low) clears both stages, the counters, the fall
// stamp and the changed flag, and loads the thresholds 20, 500 and 150 us.
// ----------------------------------------------------------------------------
// pulse_width_classifying_counter_unit
// Pulse width qualifier: times detector pulses and keeps weighted, error and
// long-pulse counts, with an APB-style port for the width thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_classifying_counter_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // APB-style configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pwcc_pkg::ApbAW-1:0]  paddr,
    input  wire logic [pwcc_pkg::ApbDW-1:0]  pwdata,
    output logic      [pwcc_pkg::ApbDW-1:0]  prdata,
    output logic                             pready,
    // Event input
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [pwcc_pkg::CmdW-1:0]   i_cmd,
    input  wire logic [pwcc_pkg::TimeW-1:0]  i_time_us,
    // Result output
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [pwcc_pkg::CntW-1:0]   o_pulse_count,
    output logic                             o_changed,
    output logic      [pwcc_pkg::WidthW-1:0] o_last_width_us,
    output logic      [pwcc_pkg::CntW-1:0]   o_error_count,
    output logic      [pwcc_pkg::CntW-1:0]   o_long_count
);
    import pwcc_pkg::*;

    t_cfg cfg;

    // Threshold registers
    pwcc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Event datapath
    pwcc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_time_us       (i_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pulse_count   (o_pulse_count),
        .o_changed       (o_changed),
        .o_last_width_us (o_last_width_us),
        .o_error_count   (o_error_count),
        .o_long_count    (o_long_count)
    );

endmodule : pulse_width_classifying_counter_unit

`default_nettype wire

// ----- rtl/pwcc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pwcc_cfg_regs
// APB-style register file holding the three pulse width thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcc_cfg_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [pwcc_pkg::ApbAW-1:0] paddr,
    input  wire logic [pwcc_pkg::ApbDW-1:0] pwdata,
    output logic      [pwcc_pkg::ApbDW-1:0] prdata,
    output logic                           pready,
    output pwcc_pkg::t_cfg                 o_cfg
);
    import pwcc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Decode writes
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DEAD_TIME:  n_cfg.dead_time_us  = pwdata[WidthW-1:0];
                REG_MAX_PULSE:  n_cfg.max_pulse_us  = pwdata[WidthW-1:0];
                REG_LONG_PULSE: n_cfg.long_pulse_us = pwdata[WidthW-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    // Hold register values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_time_us  <= DeadTimeRst;
            r_cfg.max_pulse_us  <= MaxPulseRst;
            r_cfg.long_pulse_us <= LongPulseRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_DEAD_TIME:  prdata = {{(ApbDW-WidthW){1'b0}}, r_cfg.dead_time_us};
            REG_MAX_PULSE:  prdata = {{(ApbDW-WidthW){1'b0}}, r_cfg.max_pulse_us};
            REG_LONG_PULSE: prdata = {{(ApbDW-WidthW){1'b0}}, r_cfg.long_pulse_us};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule : pwcc_cfg_regs

`default_nettype wire

// ----- rtl/pwcc_core.sv -----
// ----------------------------------------------------------------------------
// pwcc_core
// Input register, pulse classification and counter update, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcc_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pwcc_pkg::t_cfg              i_cfg,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [pwcc_pkg::CmdW-1:0]   i_cmd,
    input  wire logic [pwcc_pkg::TimeW-1:0]  i_time_us,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [pwcc_pkg::CntW-1:0]   o_pulse_count,
    output logic                             o_changed,
    output logic      [pwcc_pkg::WidthW-1:0] o_last_width_us,
    output logic      [pwcc_pkg::CntW-1:0]   o_error_count,
    output logic      [pwcc_pkg::CntW-1:0]   o_long_count
);
    import pwcc_pkg::*;

    // Input stage
    logic              r_in_valid;
    logic [CmdW-1:0]   r_cmd;
    logic [TimeW-1:0]  r_time;

    // Block state
    logic [TimeW-1:0]  r_fall_stamp, n_fall_stamp;
    logic [CntW-1:0]   r_count,      n_count;
    logic [CntW-1:0]   r_error,      n_error;
    logic [CntW-1:0]   r_long,       n_long;
    logic [WidthW-1:0] r_width,      n_width;
    logic              r_changed,    n_changed;

    // Result stage
    logic              r_out_valid;
    logic [CntW-1:0]   r_res_count;
    logic              r_res_changed;
    logic [WidthW-1:0] r_res_width;
    logic [CntW-1:0]   r_res_error;
    logic [CntW-1:0]   r_res_long;

    logic              advance;
    logic              fire;
    logic [WidthW-1:0] meas_width;
    logic              is_err;
    logic              is_long;
    logic [1:0]        weight;
    logic [CntW-1:0]   shown_count;
    logic              shown_changed;

    // Result register frees when empty or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Capture incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_time <= i_time_us;
        end
    end

    // Classify the pulse ending at this rising edge
    assign meas_width = r_time[WidthW-1:0] - r_fall_stamp[WidthW-1:0];
    assign is_err     = (meas_width < i_cfg.dead_time_us) || (meas_width > i_cfg.max_pulse_us);
    assign is_long    = meas_width > i_cfg.long_pulse_us;

    always_comb begin
        if (is_long) begin
            weight = LongWeight;
        end else if (is_err) begin
            weight = 2'd0;
        end else begin
            weight = 2'd1;
        end
    end

    // Next state and shown values
    always_comb begin
        n_fall_stamp  = r_fall_stamp;
        n_error       = r_error;
        n_long        = r_long;
        n_width       = r_width;
        shown_count   = r_count;
        shown_changed = r_changed;
        n_count       = r_count;
        n_changed     = r_changed;
        unique case (t_cmd'(r_cmd))
            CMD_FALL: begin
                n_fall_stamp = r_time;
            end
            CMD_RISE: begin
                n_width       = meas_width;
                n_error       = r_error + {{(CntW-1){1'b0}}, is_err};
                n_long        = r_long + {{(CntW-1){1'b0}}, is_long};
                shown_count   = r_count + {{(CntW-2){1'b0}}, weight};
                shown_changed = 1'b1;
                n_count       = shown_count;
                n_changed     = 1'b1;
            end
            CMD_READ: begin
                n_count   = '0;
                n_changed = 1'b0;
            end
            default: begin
                n_fall_stamp = r_fall_stamp;
            end
        endcase
    end

    // Advance block state once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall_stamp <= '0;
            r_count      <= '0;
            r_error      <= '0;
            r_long       <= '0;
            r_width      <= '0;
            r_changed    <= 1'b0;
        end else if (fire) begin
            r_fall_stamp <= n_fall_stamp;
            r_count      <= n_count;
            r_error      <= n_error;
            r_long       <= n_long;
            r_width      <= n_width;
            r_changed    <= n_changed;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res_count   <= shown_count;
            r_res_changed <= shown_changed;
            r_res_width   <= n_width;
            r_res_error   <= n_error;
            r_res_long    <= n_long;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pulse_count   = r_res_count;
    assign o_changed       = r_res_changed;
    assign o_last_width_us = r_res_width;
    assign o_error_count   = r_res_error;
    assign o_long_count    = r_res_long;

endmodule : pwcc_core

`default_nettype wire

// ----- rtl/pwcc_checker.sv -----
// ----------------------------------------------------------------------------
// pwcc_checker
// Port-level checks for the pulse width classifying counter.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        pready,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [pwcc_pkg::CntW-1:0]   o_pulse_count,
    input wire logic                        o_changed,
    input wire logic [pwcc_pkg::WidthW-1:0] o_last_width_us,
    input wire logic [pwcc_pkg::CntW-1:0]   o_error_count,
    input wire logic [pwcc_pkg::CntW-1:0]   o_long_count
);

    // Stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pulse_count)
            && $stable(o_changed) && $stable(o_last_width_us)
            && $stable(o_error_count) && $stable(o_long_count))
        else $error("result changed while stalled");

    // Empty result register never backs up the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // Accepted word reaches the output when the sink is free
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted word did not produce a result");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule : pwcc_checker

bind pulse_width_classifying_counter_unit pwcc_checker u_pwcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .pready          (pready),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pulse_count   (o_pulse_count),
    .o_changed       (o_changed),
    .o_last_width_us (o_last_width_us),
    .o_error_count   (o_error_count),
    .o_long_count    (o_long_count)
);

`default_nettype wire
